>>> rtl/core/clnw_pkg.sv
// ============================================================================
// clnw_pkg - shared types and constants for the character LCD nibble writer
// Payload structs, decoded request type, command codes and init sequence.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package clnw_pkg;

    // input item as seen on the request channel
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] value;
        logic       row_select;
        logic [3:0] column;
    } in_t;

    // result item as seen on the result channel
    typedef struct packed {
        logic [3:0] data_nibble;
        logic       reg_select;
        logic       enable_pin;
        logic       ready_res;
        logic       dropped;
    } out_t;

    // decoded request between front and back
    typedef struct packed {
        logic       has_req;
        logic       rs;
        logic [7:0] data;
    } req_t;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRCMD = 2'd1;
    localparam logic [1:0] CMD_WRCHR = 2'd2;
    localparam logic [1:0] CMD_GOTO  = 2'd3;

    // register select values
    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_CHAR = 1'b1;

    // line base addresses
    localparam logic [7:0] LINE1_BASE = 8'h80;
    localparam logic [7:0] LINE2_BASE = 8'hC0;

    // delay widths and reset values
    localparam int          DELAY_W       = 20;
    localparam logic [15:0] TPM_RESET     = 16'd1000;
    localparam int          POWERUP_MS    = 15;
    localparam logic [DELAY_W-1:0] DELAY_POWERUP = DELAY_W'(POWERUP_MS * 1000);

    // init sequence
    localparam logic [2:0] INIT_COUNT = 3'd6;
    localparam logic [7:0] INIT_RETURN_HOME = 8'h02;
    localparam logic [7:0] INIT_FUNC_SET    = 8'h28;
    localparam logic [7:0] INIT_CLEAR       = 8'h01;
    localparam logic [7:0] INIT_DISP_ON     = 8'h0C;
    localparam logic [7:0] INIT_SHIFT       = 8'h14;
    localparam logic [7:0] INIT_ENTRY_MODE  = 8'h06;

    // queue depth
    localparam int QDEPTH = 2;

    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = INIT_RETURN_HOME;
            3'd1:    b = INIT_FUNC_SET;
            3'd2:    b = INIT_CLEAR;
            3'd3:    b = INIT_DISP_ON;
            3'd4:    b = INIT_SHIFT;
            3'd5:    b = INIT_ENTRY_MODE;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/clnw_front.sv
// ============================================================================
// clnw_front - request classifier
// Decodes an incoming request into the byte to send and its register select.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module clnw_front (
    input  wire clnw_pkg::in_t  item,
    output clnw_pkg::req_t      req
);
    import clnw_pkg::*;

    // pick the byte and register select for each request type
    always_comb
    begin
        req.has_req = 1'b1;
        req.rs      = RS_CMD;
        req.data    = item.value;
        unique case (item.command)
            CMD_TICK:
            begin
                req.has_req = 1'b0;
            end
            CMD_WRCMD:
            begin
                req.rs = RS_CMD;
            end
            CMD_WRCHR:
            begin
                req.rs = RS_CHAR;
            end
            CMD_GOTO:
            begin
                req.data = (item.row_select ? LINE1_BASE : LINE2_BASE)
                           | {4'h0, item.column};
            end
            default:
            begin
                req.has_req = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/clnw_queue.sv
// ============================================================================
// clnw_queue - short request queue
// Two-entry queue between the classifier and the sequencer.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module clnw_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push_valid,
    output logic                push_stall,
    input  wire clnw_pkg::req_t push_data,
    output logic                pop_valid,
    input  wire                 pop_stall,
    output clnw_pkg::req_t      pop_data
);
    import clnw_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    req_t             mem_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_fire, pop_fire;

    // handshake
    assign push_stall = (count_reg == CNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && !push_stall;
    assign pop_fire   = pop_valid && !pop_stall;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/clnw_back.sv
// ============================================================================
// clnw_back - LCD sequencer
// Runs power-up wait, init sequence and byte transfers, one tick per item.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module clnw_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_we,
    input  wire [15:0]          cfg_data,
    input  wire                 req_valid,
    output logic                req_stall,
    input  wire clnw_pkg::req_t req,
    output logic                res_valid,
    input  wire                 res_stall,
    output clnw_pkg::out_t      res
);
    import clnw_pkg::*;

    typedef enum logic [1:0] {
        PH_POWERUP,
        PH_IDLE,
        PH_HI_WAIT,
        PH_LO_WAIT
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;
    logic [7:0]         byte_reg, byte_next;
    logic               rs_latch_reg, rs_latch_next;
    logic [2:0]         init_step_reg, init_step_next;
    logic [3:0]         nibble_reg, nibble_next;
    logic               rs_out_reg, rs_out_next;
    logic               en_reg, en_next;
    logic [15:0]        tpm_reg;
    logic               res_valid_reg, res_valid_next;
    out_t               res_reg, res_next;
    logic               step;
    logic               drop;
    logic [DELAY_W-1:0] delay_1ms, delay_3ms;

    // a tick is taken whenever the result register can hold its result
    assign req_stall = res_valid_reg && res_stall;
    assign step      = req_valid && !req_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // delay loads from the current tick rate
    assign delay_1ms = {4'h0, tpm_reg};
    assign delay_3ms = {3'b000, tpm_reg, 1'b0} + {4'h0, tpm_reg};

    // sequencer next state
    always_comb
    begin
        phase_next     = phase_reg;
        delay_next     = delay_reg;
        byte_next      = byte_reg;
        rs_latch_next  = rs_latch_reg;
        init_step_next = init_step_reg;
        nibble_next    = nibble_reg;
        rs_out_next    = rs_out_reg;
        en_next        = en_reg;
        drop           = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            en_next = 1'b0;
            if (req.has_req)
            begin
                byte_next     = req.data;
                rs_latch_next = req.rs;
                nibble_next   = req.data[7:4];
                rs_out_next   = req.rs;
                en_next       = 1'b1;
                phase_next    = PH_HI_WAIT;
                delay_next    = delay_1ms;
            end
        end
        else
        begin
            drop = req.has_req;
            priority if (delay_reg != '0)
            begin
                en_next    = 1'b0;
                delay_next = delay_reg - 1'b1;
            end
            else if (phase_reg == PH_HI_WAIT)
            begin
                nibble_next = byte_reg[3:0];
                rs_out_next = rs_latch_reg;
                en_next     = 1'b1;
                phase_next  = PH_LO_WAIT;
                delay_next  = delay_3ms;
            end
            else if (init_step_reg < INIT_COUNT)
            begin
                byte_next      = init_byte(init_step_reg);
                rs_latch_next  = RS_CMD;
                nibble_next    = byte_next[7:4];
                rs_out_next    = RS_CMD;
                en_next        = 1'b1;
                phase_next     = PH_HI_WAIT;
                delay_next     = delay_1ms;
                init_step_next = init_step_reg + 1'b1;
            end
            else
            begin
                en_next    = 1'b0;
                phase_next = PH_IDLE;
            end
        end

        res_next.data_nibble = nibble_next;
        res_next.reg_select  = rs_out_next;
        res_next.enable_pin  = en_next;
        res_next.ready_res   = (phase_next == PH_IDLE);
        res_next.dropped     = drop;
    end

    // result register valid
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (step)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    // state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_POWERUP;
            delay_reg     <= DELAY_POWERUP;
            byte_reg      <= '0;
            rs_latch_reg  <= 1'b0;
            init_step_reg <= '0;
            nibble_reg    <= '0;
            rs_out_reg    <= 1'b0;
            en_reg        <= 1'b0;
            tpm_reg       <= TPM_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                tpm_reg <= cfg_data;
            end
            if (step)
            begin
                phase_reg     <= phase_next;
                delay_reg     <= delay_next;
                byte_reg      <= byte_next;
                rs_latch_reg  <= rs_latch_next;
                init_step_reg <= init_step_next;
                nibble_reg    <= nibble_next;
                rs_out_reg    <= rs_out_next;
                en_reg        <= en_next;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/char_lcd_nibble_writer_top.sv
// ============================================================================
// char_lcd_nibble_writer_top - character LCD writer on a 4-bit bus
// Classifier, request queue and sequencer for a character display.
// ============================================================================
// Usage:
//   in_valid/in_stall/in_data carry one item per tick: a plain tick, a
//   command byte, a character byte, or a go-to-position request.
//   out_valid/out_stall/out_data return one result per item: the data
//   nibble, register select and enable lines after that tick, the ready
//   flag and a dropped flag for requests that came in while busy.
//   cfg_we/cfg_data write ticks_per_ms; write it only while idle.
// Timing:
//   an item is classified and written into the queue on its transfer edge;
//   the sequencer then takes it from the queue and registers its result,
//   which is offered from then on. One item per cycle is sustained while
//   out_stall is low; the sequencer step plus the result register set it.
// Reset:
//   the sequencer starts in the 15 ms power-up wait and then sends the six
//   init bytes; ticks_per_ms returns to 1000.
// Stall:
//   a stalled result holds, the sequencer halts, and the two-entry queue
//   fills before in_stall is raised.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_writer_top (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_we,
    input  wire [15:0]         cfg_data,
    input  wire                in_valid,
    output logic               in_stall,
    input  wire clnw_pkg::in_t in_data,
    output logic               out_valid,
    input  wire                out_stall,
    output clnw_pkg::out_t     out_data
);
    import clnw_pkg::*;

    req_t dec_req;
    req_t q_req;
    logic q_valid;
    logic q_stall;

    // classify incoming requests
    clnw_front u_front (
        .item (in_data),
        .req  (dec_req)
    );

    // queue between classifier and sequencer
    clnw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_stall (in_stall),
        .push_data  (dec_req),
        .pop_valid  (q_valid),
        .pop_stall  (q_stall),
        .pop_data   (q_req)
    );

    // sequencer and result register
    clnw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .req_valid (q_valid),
        .req_stall (q_stall),
        .req       (q_req),
        .res_valid (out_valid),
        .res_stall (out_stall),
        .res       (out_data)
    );

endmodule

`default_nettype wire

>>> test/char_lcd_nibble_writer_top_tb.sv
// ============================================================================
// char_lcd_nibble_writer_top_tb - testbench for the character LCD writer
// Runs power-up and init, then directed byte, character and cursor requests,
// zero and maximum delay scaling, a long result hold-off and random traffic.
// Every result is checked against a tick-by-tick model of the sequencer.
// ============================================================================
`timescale 1ns / 1ps

module char_lcd_nibble_writer_top_tb;

    import clnw_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 150;

    typedef enum logic [1:0] {
        SEQ_POWERUP,
        SEQ_IDLE,
        SEQ_HI_WAIT,
        SEQ_LO_WAIT
    } seq_phase_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_data  = 16'd0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    in_t         in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_t        out_data;

    // model of the display sequencer
    seq_phase_t           seq_phase;
    logic [DELAY_W-1:0]   delay_cnt;
    logic [7:0]           byte_q;
    logic                 rs_q;
    logic [2:0]           init_idx;
    logic [3:0]           nib_q;
    logic                 rs_pin;
    logic                 en_pin;
    logic [15:0]          tpm_q;
    logic [7:0]           init_seq [0:5];

    // pin states still owed by the block, oldest first
    out_t lcd_pins_due [$];

    int   fail_count  = 0;
    bit   tx_idle_on  = 1'b1;
    bit   rx_idle_on  = 1'b1;
    logic hold_toggle = 1'b0;
    logic hold_seen   = 1'b0;
    int   hold_left   = 0;
    int   wait_left   = 0;
    int   quiet_cycles = 0;

    char_lcd_nibble_writer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // sequencer state after reset
    function automatic void reset_lcd_model();
        tpm_q       = TPM_RESET;
        seq_phase   = SEQ_POWERUP;
        delay_cnt   = DELAY_W'(POWERUP_MS * int'(TPM_RESET));
        byte_q      = 8'h00;
        rs_q        = RS_CMD;
        init_idx    = 3'd0;
        nib_q       = 4'h0;
        rs_pin      = RS_CMD;
        en_pin      = 1'b0;
        init_seq[0] = INIT_RETURN_HOME;
        init_seq[1] = INIT_FUNC_SET;
        init_seq[2] = INIT_CLEAR;
        init_seq[3] = INIT_DISP_ON;
        init_seq[4] = INIT_SHIFT;
        init_seq[5] = INIT_ENTRY_MODE;
    endfunction

    // latch a byte and pulse its high nibble
    function automatic void byte_start(input logic [7:0] b, input logic rs);
        byte_q    = b;
        rs_q      = rs;
        nib_q     = b[7:4];
        rs_pin    = rs;
        en_pin    = 1'b1;
        seq_phase = SEQ_HI_WAIT;
        delay_cnt = DELAY_W'(tpm_q);
    endfunction

    // advance the sequencer by one tick and return the pins after it
    function automatic out_t lcd_step(input in_t it);
        out_t r;
        logic drop;
        drop = 1'b0;
        if (seq_phase == SEQ_IDLE)
        begin
            en_pin = 1'b0;
            case (it.command)
                CMD_WRCMD: byte_start(it.value, RS_CMD);
                CMD_WRCHR: byte_start(it.value, RS_CHAR);
                CMD_GOTO:  byte_start((it.row_select ? LINE1_BASE : LINE2_BASE)
                                      | {4'h0, it.column}, RS_CMD);
                default:   ;
            endcase
        end
        else
        begin
            if (it.command != CMD_TICK)
                drop = 1'b1;
            if (delay_cnt != '0)
            begin
                en_pin    = 1'b0;
                delay_cnt = delay_cnt - 1'b1;
            end
            else if (seq_phase == SEQ_HI_WAIT)
            begin
                nib_q     = byte_q[3:0];
                rs_pin    = rs_q;
                en_pin    = 1'b1;
                seq_phase = SEQ_LO_WAIT;
                delay_cnt = DELAY_W'(3 * int'(tpm_q));
            end
            else if (init_idx < INIT_COUNT)
            begin
                // power-up wait or previous init byte done
                byte_start(init_seq[init_idx], RS_CMD);
                init_idx = init_idx + 3'd1;
            end
            else
            begin
                en_pin    = 1'b0;
                seq_phase = SEQ_IDLE;
            end
        end
        r.data_nibble = nib_q;
        r.reg_select  = rs_pin;
        r.enable_pin  = en_pin;
        r.ready_res   = (seq_phase == SEQ_IDLE);
        r.dropped     = drop;
        return r;
    endfunction

    function automatic in_t rand_tick();
        in_t it;
        it.command    = CMD_TICK;
        it.value      = 8'($urandom);
        it.row_select = 1'($urandom);
        it.column     = 4'($urandom);
        return it;
    endfunction

    function automatic in_t rand_request();
        in_t it;
        it = rand_tick();
        case ($urandom_range(0, 2))
            0:       it.command = CMD_WRCMD;
            1:       it.command = CMD_WRCHR;
            default: it.command = CMD_GOTO;
        endcase
        return it;
    endfunction

    // request while idle with req_pct odds, stray request while busy with noise_pct
    function automatic in_t pick_item(input int req_pct, input int noise_pct);
        if (seq_phase == SEQ_IDLE)
            return ($urandom_range(0, 99) < req_pct) ? rand_request() : rand_tick();
        return ($urandom_range(0, 99) < noise_pct) ? rand_request() : rand_tick();
    endfunction

    // one input transfer; valid stays up so a following item can go back to back
    task automatic send_item(input in_t it);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        lcd_pins_due.push_back(lcd_step(it));
    endtask

    // stop sending and wait for every owed result
    task automatic drain_results();
        in_valid <= 1'b0;
        while (lcd_pins_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_tpm(input logic [15:0] v);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        tpm_q     = v;
    endtask

    task automatic ticks_until_ready(input int noise_pct);
        while (seq_phase != SEQ_IDLE)
            send_item(pick_item(0, noise_pct));
    endtask

    // power-up wait, then the six init bytes
    task automatic test_powerup_init();
        write_tpm(16'd2);
        for (int i = 0; i < 300; i++)
            send_item(pick_item(0, 3));
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        while (seq_phase == SEQ_POWERUP)
            send_item(pick_item(0, 1));
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        ticks_until_ready(5);
    endtask

    // field extremes for each request kind, stray requests while busy
    task automatic test_directed_requests();
        in_t reqs [7];
        write_tpm(16'd1);
        reqs[0] = '{command: CMD_WRCMD, value: 8'h00, row_select: 1'b0, column: 4'h0};
        reqs[1] = '{command: CMD_WRCMD, value: 8'hFF, row_select: 1'b1, column: 4'hF};
        reqs[2] = '{command: CMD_WRCHR, value: 8'h5A, row_select: 1'b0, column: 4'h0};
        reqs[3] = '{command: CMD_WRCHR, value: 8'hA5, row_select: 1'b1, column: 4'hF};
        reqs[4] = '{command: CMD_GOTO,  value: 8'hFF, row_select: 1'b1, column: 4'hF};
        reqs[5] = '{command: CMD_GOTO,  value: 8'h00, row_select: 1'b0, column: 4'h0};
        reqs[6] = '{command: CMD_GOTO,  value: 8'h3C, row_select: 1'b0, column: 4'hF};
        foreach (reqs[i])
        begin
            send_item(reqs[i]);
            send_item(rand_request());
            ticks_until_ready(25);
            if (i % 2 == 0)
                send_item(rand_tick());
        end
    endtask

    // no delay ticks at all, only the pulse ticks
    task automatic test_zero_delay();
        write_tpm(16'd0);
        for (int i = 0; i < 12; i++)
        begin
            send_item(rand_request());
            ticks_until_ready(30);
        end
    endtask

    // results held off while the sender keeps going, then a full pause
    task automatic test_backpressure();
        write_tpm(16'd3);
        tx_idle_on = 1'b0;
        hold_toggle <= ~hold_toggle;
        for (int i = 0; i < 40; i++)
            send_item(pick_item(80, 10));
        tx_idle_on = 1'b1;
        drain_results();
        for (int i = 0; i < 20; i++)
            send_item(pick_item(80, 10));
    endtask

    // widest delay; a mid-delay register change leaves the running count alone
    task automatic test_max_delay();
        write_tpm(16'hFFFF);
        send_item(rand_request());
        for (int i = 0; i < 2000; i++)
            send_item(pick_item(0, 2));
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        write_tpm(16'd1);
        ticks_until_ready(1);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // well-formed request streams with stray requests, several delay settings
    task automatic test_random_traffic();
        logic [15:0] tpm_set [6];
        tpm_set[0] = 16'd1;
        tpm_set[1] = 16'd2;
        tpm_set[2] = 16'($urandom_range(0, 6));
        tpm_set[3] = 16'd4;
        tpm_set[4] = 16'd0;
        tpm_set[5] = 16'($urandom_range(1, 5));
        foreach (tpm_set[p])
        begin
            write_tpm(tpm_set[p]);
            for (int i = 0; i < 75; i++)
            begin
                if (i % 25 == 0)
                begin
                    tx_idle_on = 1'($urandom_range(0, 2) != 0);
                    rx_idle_on = 1'($urandom_range(0, 2) != 0);
                end
                send_item(pick_item(70, 8));
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // result side: check each transfer, then pick the next stall
    always @(posedge clk)
    begin : result_side
        out_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (lcd_pins_due.size() == 0)
                begin
                    $error("result transfer with nothing pending: %h", out_data);
                    fail_count++;
                end
                else
                begin
                    want = lcd_pins_due.pop_front();
                    if (out_data.data_nibble !== want.data_nibble)
                    begin
                        $error("data_nibble: expected %h, got %h",
                               want.data_nibble, out_data.data_nibble);
                        fail_count++;
                    end
                    if (out_data.reg_select !== want.reg_select)
                    begin
                        $error("reg_select: expected %b, got %b",
                               want.reg_select, out_data.reg_select);
                        fail_count++;
                    end
                    if (out_data.enable_pin !== want.enable_pin)
                    begin
                        $error("enable_pin: expected %b, got %b",
                               want.enable_pin, out_data.enable_pin);
                        fail_count++;
                    end
                    if (out_data.ready_res !== want.ready_res)
                    begin
                        $error("ready_res: expected %b, got %b",
                               want.ready_res, out_data.ready_res);
                        fail_count++;
                    end
                    if (out_data.dropped !== want.dropped)
                    begin
                        $error("dropped: expected %b, got %b",
                               want.dropped, out_data.dropped);
                        fail_count++;
                    end
                end
                wait_left = rx_idle_on ? $urandom_range(0, 8) : 0;
            end
            if (hold_toggle != hold_seen)
            begin
                hold_seen = hold_toggle;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (wait_left != 0)
            begin
                wait_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        reset_lcd_model();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_powerup_init();
        test_directed_requests();
        test_zero_delay();
        test_backpressure();
        test_max_delay();
        test_random_traffic();
        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
